// File: design/rdpq_pkg.sv
package rdpq_pkg;

  localparam int unsigned STEP_SIZE    = 51;
  localparam int unsigned GREY_SPREAD  = 12;
  localparam int unsigned GREY_BIAS    = 24;
  localparam int unsigned GREY_BASE    = 216;
  localparam int unsigned GREY_STEPS   = 40;
  localparam int unsigned CUBE_TOP     = 5;
  localparam int unsigned CUBE_ROW     = 36;
  localparam int unsigned CUBE_COL     = 6;
  localparam int unsigned ROUND_BIAS   = 127;
  // floor(x/3) == (x*683)>>11 for every x up to 765
  localparam int unsigned RECIP3       = 683;
  localparam int unsigned RECIP3_SHIFT = 11;

  // stage 1: channels, dither offset, channel sum, near-grey flag
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [5:0] off;
    logic [9:0] sum;
    logic       grey;
  } s1_t;

  // stage 2: cube levels and clamped grey level
  typedef struct packed {
    logic [2:0] lvl_r;
    logic [2:0] lvl_g;
    logic [2:0] lvl_b;
    logic [7:0] grey_lvl;
    logic       grey;
  } s2_t;

  // stage 3: cube index and grey numerator v*39+127
  typedef struct packed {
    logic [7:0]  cube;
    logic [13:0] grey_num;
    logic        grey;
  } s3_t;

  // floor(t*51/16) of the 4x4 Bayer threshold
  function automatic logic [5:0] dither_offset(input logic [1:0] row, input logic [1:0] col);
    logic [3:0] thr;
    logic [9:0] prod;
    case ({row, col})
      4'd0:    thr = 4'd0;
      4'd1:    thr = 4'd8;
      4'd2:    thr = 4'd2;
      4'd3:    thr = 4'd10;
      4'd4:    thr = 4'd12;
      4'd5:    thr = 4'd4;
      4'd6:    thr = 4'd14;
      4'd7:    thr = 4'd6;
      4'd8:    thr = 4'd3;
      4'd9:    thr = 4'd11;
      4'd10:   thr = 4'd1;
      4'd11:   thr = 4'd9;
      4'd12:   thr = 4'd15;
      4'd13:   thr = 4'd7;
      4'd14:   thr = 4'd13;
      4'd15:   thr = 4'd5;
      default: thr = 4'd0;
    endcase
    prod = 10'(thr) * 10'(STEP_SIZE);
    return prod[9:4];
  endfunction

  // |a-b| < GREY_SPREAD
  function automatic logic close(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d < 8'(GREY_SPREAD);
  endfunction

  // floor((c+off)/51); the sum never reaches 306, so it saturates at 5 by itself
  function automatic logic [2:0] cube_level(input logic [7:0] c, input logic [5:0] off);
    logic [8:0] x;
    logic [2:0] n;
    x = 9'(c) + 9'(off);
    n = 3'd0;
    for (int k = 1; k <= int'(CUBE_TOP); k++) begin
      if (x >= 9'(k * STEP_SIZE)) n = 3'(k);
    end
    return n;
  endfunction

endpackage

// File: design/rgb_dither_palette_quantizer.sv
// A start transfer reaches done with its result after passing the stages listed below.
// Throughput: one pixel per cycle; busy is tied low, four pixels in flight.
// Stages: offset/sum/grey test, /3 multiply and cube levels, index math, /255 and select.
// Reset (rst, synchronous, active high) clears every stage valid bit; payload is not reset.
// The receiver cannot stall: each result shows on palette_index for one cycle with done.
module rgb_dither_palette_quantizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [1:0] column_phase,
  input  logic [1:0] row_phase,
  output logic       done,
  output logic [7:0] palette_index
);

  logic            accept;
  logic            s1_valid;
  rdpq_pkg::s1_t   s1;
  logic            s2_valid;
  rdpq_pkg::s2_t   s2;

  // Every stage advances every cycle and the sink always takes the result,
  // so there is never a reason to hold a transfer off.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage 1: Bayer offset lookup, channel sum and near-grey test.
  rdpq_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (accept),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .column_phase (column_phase),
    .row_phase    (row_phase),
    .s1_valid     (s1_valid),
    .s1           (s1)
  );

  // Stage 2: grey level via reciprocal multiply by 1/3, clamp; cube levels
  // by threshold compares against multiples of 51.
  rdpq_level u_level (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2       (s2)
  );

  // Stages 3 and 4: cube index r*36+g*6+b and grey numerator, then the
  // divide by 255, ramp offset and path select into the output register.
  rdpq_index u_index (
    .clk           (clk),
    .rst           (rst),
    .s2_valid      (s2_valid),
    .s2            (s2),
    .done          (done),
    .palette_index (palette_index)
  );

  // each accepted pixel yields a done strobe
  assert property (@(posedge clk) disable iff (rst) accept |-> ##4 done)
    else $error("result missing four cycles after transfer");

  // no result without a matching accepted pixel
  assert property (@(posedge clk) disable iff (rst) done |-> $past(accept, 4))
    else $error("result without matching input transfer");

  // the stage 2 valid bit follows the stage 1 valid bit in the next cycle
  assert property (@(posedge clk) disable iff (rst) s1_valid |=> s2_valid)
    else $error("pipeline valid bit dropped between stages");

endmodule

// File: design/rdpq_front.sv
module rdpq_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [7:0]       red,
  input  logic [7:0]       green,
  input  logic [7:0]       blue,
  input  logic [1:0]       column_phase,
  input  logic [1:0]       row_phase,
  output logic             s1_valid,
  output rdpq_pkg::s1_t    s1
);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1.red   <= red;
    s1.green <= green;
    s1.blue  <= blue;
    s1.off   <= rdpq_pkg::dither_offset(row_phase, column_phase);
    s1.sum   <= 10'(red) + 10'(green) + 10'(blue);
    s1.grey  <= rdpq_pkg::close(red, green) && rdpq_pkg::close(green, blue)
             && rdpq_pkg::close(red, blue);
  end

endmodule

// File: design/rdpq_level.sv
module rdpq_level (
  input  logic             clk,
  input  logic             rst,
  input  logic             s1_valid,
  input  rdpq_pkg::s1_t    s1,
  output logic             s2_valid,
  output rdpq_pkg::s2_t    s2
);

  logic [19:0] prod3;
  logic [8:0]  third;
  logic [9:0]  grey_raw;   // two's complement, -24..278
  logic [7:0]  grey_clamp;

  always_comb begin
    prod3      = 20'(s1.sum) * 20'(rdpq_pkg::RECIP3);
    third      = 9'(prod3 >> rdpq_pkg::RECIP3_SHIFT);
    grey_raw   = 10'(third) + 10'(s1.off) - 10'(rdpq_pkg::GREY_BIAS);
    if (grey_raw[9]) begin
      grey_clamp = 8'd0;
    end else if (grey_raw[8]) begin
      grey_clamp = 8'hff;
    end else begin
      grey_clamp = grey_raw[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2.lvl_r    <= rdpq_pkg::cube_level(s1.red, s1.off);
    s2.lvl_g    <= rdpq_pkg::cube_level(s1.green, s1.off);
    s2.lvl_b    <= rdpq_pkg::cube_level(s1.blue, s1.off);
    s2.grey_lvl <= grey_clamp;
    s2.grey     <= s1.grey;
  end

endmodule

// File: design/rdpq_index.sv
module rdpq_index (
  input  logic             clk,
  input  logic             rst,
  input  logic             s2_valid,
  input  rdpq_pkg::s2_t    s2,
  output logic             done,
  output logic [7:0]       palette_index
);

  logic            s3_valid;
  rdpq_pkg::s3_t   s3;
  logic [14:0]     num_p1;
  logic [14:0]     quot;
  logic [7:0]      index_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
      done     <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3.cube     <= 8'(s2.lvl_r) * 8'(rdpq_pkg::CUBE_ROW)
                 + 8'(s2.lvl_g) * 8'(rdpq_pkg::CUBE_COL) + 8'(s2.lvl_b);
    s3.grey_num <= 14'(s2.grey_lvl) * 14'(rdpq_pkg::GREY_STEPS - 1)
                 + 14'(rdpq_pkg::ROUND_BIAS);
    s3.grey     <= s2.grey;
  end

  // floor(x/255) = (y + (y>>8)) >> 8 with y = x+1, exact for the 14-bit grey_num used here
  always_comb begin
    num_p1 = 15'(s3.grey_num) + 15'd1;
    quot   = (num_p1 + (num_p1 >> 8)) >> 8;
    if (s3.grey) begin
      index_next = 8'(rdpq_pkg::GREY_BASE) + quot[7:0];
    end else begin
      index_next = s3.cube;
    end
  end

  always_ff @(posedge clk) begin
    palette_index <= index_next;
  end

  // grey path always lands on the grey ramp, cube path never does
  assert property (@(posedge clk) disable iff (rst)
    s3_valid |=> ($past(s3.grey) == (palette_index >= 8'(rdpq_pkg::GREY_BASE))))
    else $error("grey/cube path landed in wrong palette region");

endmodule

// File: tb/sv/tb_rgb_dither_palette_quantizer.sv
`timescale 1ns / 100ps

module tb_rgb_dither_palette_quantizer;

  // One pixel to send, plus the number of idle cycles in front of its transfer.
  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] col;
    logic [1:0] row;
    int         gap;
  } pixel_t;

  // 4x4 Bayer thresholds, indexed by {row, col}
  localparam logic [3:0] BAYER [16] = '{
    4'd0,  4'd8,  4'd2,  4'd10,
    4'd12, 4'd4,  4'd14, 4'd6,
    4'd3,  4'd11, 4'd1,  4'd9,
    4'd15, 4'd7,  4'd13, 4'd5
  };

  localparam int RANDOM_PIXELS = 650;
  localparam int TAIL_CYCLES   = 10;

  logic       clk;
  logic       rst;
  logic       start        = 1'b0;
  logic       busy;
  logic [7:0] red          = 8'd0;
  logic [7:0] green        = 8'd0;
  logic [7:0] blue         = 8'd0;
  logic [1:0] column_phase = 2'd0;
  logic [1:0] row_phase    = 2'd0;
  logic       done;
  logic [7:0] palette_index;

  pixel_t     pixel_q[$];     // pixels waiting for the driver
  logic [7:0] index_q[$];     // predicted palette indexes, oldest first
  int         pixels_queued = 0;
  int         pixels_sent   = 0;
  int         errors        = 0;
  logic       taken         = 1'b0; // start transfer happened at the last rising edge

  rgb_dither_palette_quantizer u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .column_phase (column_phase),
    .row_phase    (row_phase),
    .done         (done),
    .palette_index(palette_index)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Palette index for one pixel: grey ramp for near-grey pixels, colour cube otherwise.
  function automatic logic [7:0] quantize_pixel(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b, input logic [1:0] col,
                                                input logic [1:0] row);
    int rc, gc, bc, off, spread, lvl, lr, lg, lb, idx, step, top;
    rc     = int'(r);
    gc     = int'(g);
    bc     = int'(b);
    spread = int'(rdpq_pkg::GREY_SPREAD);
    step   = int'(rdpq_pkg::STEP_SIZE);
    top    = int'(rdpq_pkg::CUBE_TOP);
    off    = (int'(BAYER[{row, col}]) * step) / 16;
    if (rc - gc < spread && gc - rc < spread && gc - bc < spread &&
        bc - gc < spread && rc - bc < spread && bc - rc < spread) begin
      lvl = (rc + gc + bc) / 3 + off - int'(rdpq_pkg::GREY_BIAS);
      if (lvl < 0) lvl = 0;
      else if (lvl > 255) lvl = 255;
      idx = int'(rdpq_pkg::GREY_BASE)
          + (lvl * (int'(rdpq_pkg::GREY_STEPS) - 1) + int'(rdpq_pkg::ROUND_BIAS)) / 255;
    end else begin
      lr = (rc + off) / step;
      lg = (gc + off) / step;
      lb = (bc + off) / step;
      if (lr > top) lr = top;
      if (lg > top) lg = top;
      if (lb > top) lb = top;
      idx = lr * int'(rdpq_pkg::CUBE_ROW) + lg * int'(rdpq_pkg::CUBE_COL) + lb;
    end
    return 8'(idx);
  endfunction

  // Idle length in front of a transfer: none when quiet, else mostly none or short, now and then long.
  function automatic int pick_gap(input bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_pixel(input int r, input int g, input int b, input int col,
                           input int row, input int gap);
    pixel_t p;
    p.red   = 8'(r);
    p.green = 8'(g);
    p.blue  = 8'(b);
    p.col   = 2'(col);
    p.row   = 2'(row);
    p.gap   = gap;
    pixel_q.push_back(p);
    pixels_queued++;
  endtask

  // Channel near a grey base, pushed up to a little past the grey spread.
  function automatic int near_grey(input int base);
    int c;
    c = base + $urandom_range(0, 26) - 13;
    if (c < 0) c = 0;
    if (c > 255) c = 255;
    return c;
  endfunction

  // Driver: presents pixels at the falling edge, holds start until the transfer is taken.
  always @(negedge clk) begin
    pixel_t    nxt;
    static int     gap_left  = 0;
    static bit     have_item = 1'b0;
    static pixel_t cur;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      // transfer still pending: keep everything as it is
    end else if (gap_left > 0) begin
      start    <= 1'b0;
      gap_left  = gap_left - 1;
    end else if (have_item) begin
      start        <= 1'b1;
      red          <= cur.red;
      green        <= cur.green;
      blue         <= cur.blue;
      column_phase <= cur.col;
      row_phase    <= cur.row;
      have_item     = 1'b0;
    end else if (pixel_q.size() > 0) begin
      nxt = pixel_q.pop_front();
      if (nxt.gap == 0) begin
        start        <= 1'b1;
        red          <= nxt.red;
        green        <= nxt.green;
        blue         <= nxt.blue;
        column_phase <= nxt.col;
        row_phase    <= nxt.row;
      end else begin
        start    <= 1'b0;
        cur       = nxt;
        have_item = 1'b1;
        gap_left  = nxt.gap - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: predicts on each start transfer, checks each done strobe against the oldest.
  always @(posedge clk) begin
    logic [7:0] want;
    if (rst) begin
      taken <= 1'b0;
    end else begin
      taken <= start && !busy;
      if (start && !busy) begin
        index_q.push_back(quantize_pixel(red, green, blue, column_phase, row_phase));
        pixels_sent++;
      end
      if (done) begin
        if (index_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: expected none, actual %0d",
                   $realtime, palette_index);
        end else begin
          want = index_q.pop_front();
          if (palette_index !== want) begin
            errors++;
            $display("%0t: palette_index mismatch: expected %0d, actual %0d",
                     $realtime, want, palette_index);
          end
        end
      end
    end
  end

  initial begin
    int base;
    bit quiet;
    rst = 1'b1;

    // Directed: grey sweep from black to white across all 16 dither phases.
    for (int ph = 0; ph < 16; ph++) begin
      add_pixel(ph * 17, ph * 17, ph * 17, ph % 4, ph / 4, pick_gap(1'b0));
    end
    add_pixel(255, 255, 255, 0, 3, 0);   // white at the largest offset, grey clamp at 255
    add_pixel(10, 10, 10, 0, 0, 0);      // dark grey below the bias, clamps to 0
    add_pixel(100, 111, 100, 1, 0, 0);   // pair spread just inside the grey test
    add_pixel(100, 112, 100, 1, 0, 1);   // pair spread just outside: cube path
    add_pixel(112, 100, 100, 2, 1, 0);
    add_pixel(100, 100, 112, 3, 2, 0);
    add_pixel(0, 255, 0, 0, 3, 2);       // pure green, saturated level
    add_pixel(255, 0, 255, 0, 3, 0);     // cube levels saturate at the top
    add_pixel(50, 0, 0, 0, 0, 0);        // just below the first cube step with no offset

    // Random: blocks alternate between back-to-back and gappy traffic.
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      quiet = ((i / 50) % 2) == 1;
      if ($urandom_range(0, 99) < 45) begin
        base = $urandom_range(0, 255);
        add_pixel(near_grey(base), near_grey(base), near_grey(base),
                  $urandom_range(0, 3), $urandom_range(0, 3), pick_gap(quiet));
      end else begin
        add_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 3), $urandom_range(0, 3), pick_gap(quiet));
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pixels_sent != pixels_queued) @(posedge clk);
    while (index_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && index_q.size() == 0) begin
      $display("tb_rgb_dither_palette_quantizer: PASS");
    end else begin
      $display("tb_rgb_dither_palette_quantizer: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_rgb_dither_palette_quantizer: FAIL");
    $finish;
  end

endmodule
